// ===== hdl/sorted_version_set_defines.svh =====
// ----------------------------------------------------------------------------
// sorted_version_set_defines
// Assertion macros used by the sorted version set sequencer (svs_ctrl).
// ----------------------------------------------------------------------------
`ifndef SORTED_VERSION_SET_DEFINES_SVH
`define SORTED_VERSION_SET_DEFINES_SVH

// Check that cons holds in the cycle after ante.
`define SVS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted version set: next-cycle check failed");

// Check that cons holds in the same cycle as ante.
`define SVS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted version set: same-cycle check failed");

`endif

// ===== hdl/svs_pkg.sv =====
// ----------------------------------------------------------------------------
// svs_pkg
// Types and constants of the sorted version set.
// ----------------------------------------------------------------------------
`default_nettype none

package svs_pkg;

   // Store size and stored id width
   localparam int CAPACITY = 64;
   localparam int ID_WIDTH = 32;

   // Commands
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_DUPLICATE = 2'd1;
   localparam logic [1:0] STATUS_ABSENT    = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   typedef logic [ID_WIDTH-1:0] id_type;

   typedef struct packed {
      logic        command;
      logic [31:0] version_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] lower_neighbour;
      logic [31:0] upper_neighbour;
      logic        set_empty;
   } rsp_type;

   // Sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   // Broadcast from the sequencer to every cell
   typedef struct packed {
      logic   cmp_en;
      id_type cmp_key;
      id_type upd_key;
      logic   do_insert;
      logic   do_remove;
   } cell_ctrl_type;

   // What a cell shows its neighbors
   typedef struct packed {
      id_type id;
      logic   valid;
      logic   lt;
      logic   eq;
   } link_type;

   // Summary of the cell row for the sequencer
   typedef struct packed {
      logic   found;
      logic   full;
      logic   valid0;
      logic   valid1;
      logic   lo_hit;
      id_type lo_id;
      logic   hi_hit;
      id_type hi_id;
   } row_status_type;

endpackage

`default_nettype wire

// ===== hdl/svs_cell.sv =====
// ----------------------------------------------------------------------------
// svs_cell
// One slot of the sorted store: compares its id with the key, then keeps,
// takes the key, or shifts in a neighbor's id.
// ----------------------------------------------------------------------------
`default_nettype none

module svs_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   reset_valid,
   input  wire svs_pkg::cell_ctrl_type ctrl,
   input  wire svs_pkg::link_type      left,
   input  wire svs_pkg::link_type      right,
   output svs_pkg::link_type           link_out,
   output logic                        lo_hit,
   output logic                        hi_hit
);
   import svs_pkg::*;

   id_type id_ff, id_in;
   logic   valid_ff, valid_in;
   logic   lt_ff, lt_in;
   logic   eq_ff, eq_in;

   // Compare on accept, shift on commit
   always_comb begin
      id_in    = id_ff;
      valid_in = valid_ff;
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      if (ctrl.cmp_en) begin
         lt_in = valid_ff && (id_ff < ctrl.cmp_key);
         eq_in = valid_ff && (id_ff == ctrl.cmp_key);
      end
      if (ctrl.do_insert && !lt_ff) begin
         if (left.lt) begin
            id_in    = ctrl.upd_key;
            valid_in = 1'b1;
         end else begin
            id_in    = left.id;
            valid_in = left.valid;
         end
      end else if (ctrl.do_remove && !lt_ff) begin
         id_in    = right.id;
         valid_in = right.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff    <= '0;
         valid_ff <= reset_valid;
         lt_ff    <= 1'b0;
         eq_ff    <= 1'b0;
      end else begin
         id_ff    <= id_in;
         valid_ff <= valid_in;
         lt_ff    <= lt_in;
         eq_ff    <= eq_in;
      end
   end

   // Flag this slot as a neighbor of the matching slot
   assign lo_hit   = lt_ff && right.eq;
   assign hi_hit   = left.eq && valid_ff;
   assign link_out = '{id: id_ff, valid: valid_ff, lt: lt_ff, eq: eq_ff};

endmodule

`default_nettype wire

// ===== hdl/svs_ctrl.sv =====
// ----------------------------------------------------------------------------
// svs_ctrl
// Sequencer of the sorted version set: takes a request, drives the cell row
// through its update and builds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_version_set_defines.svh"

module svs_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire svs_pkg::req_type        req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output svs_pkg::rsp_type             rsp_data,
   input  wire logic                    csr_write_en,
   input  wire logic [31:0]             csr_write_data,
   input  wire svs_pkg::row_status_type row,
   output svs_pkg::cell_ctrl_type       cell_ctrl
);
   import svs_pkg::*;

   state_type   state_ff, state_in;
   id_type      key_ff, key_in;
   logic        cmd_ff, cmd_in;
   logic [31:0] invalid_ff, invalid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic   accept;
   logic   fire;
   logic   insert_ok;
   logic   remove_ok;
   id_type lo_val;
   id_type hi_val;

   assign accept = req_valid && (state_ff == ST_IDLE);
   assign fire   = (state_ff == ST_UPDATE) && (!rsp_valid_ff || !rsp_stall);
   assign insert_ok = fire && (cmd_ff == CMD_INSERT) && !row.found && !row.full;
   assign remove_ok = fire && (cmd_ff == CMD_REMOVE) && row.found;

   // Missing neighbors fall back to key-1 and key+1
   assign lo_val = row.lo_hit ? row.lo_id : (key_ff - id_type'(1));
   assign hi_val = row.hi_hit ? row.hi_id : (key_ff + id_type'(1));

   // Next state, request capture and result build
   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      cmd_in       = cmd_ff;
      invalid_in   = invalid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (csr_write_en) begin
         invalid_in = csr_write_data;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in   = id_type'(req_data.version_id);
               cmd_in   = req_data.command;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (fire) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.lower_neighbour = '0;
               rsp_data_in.upper_neighbour = '0;
               if (cmd_ff == CMD_INSERT) begin
                  if (row.found) begin
                     rsp_data_in.status = STATUS_DUPLICATE;
                  end else if (row.full) begin
                     rsp_data_in.status = STATUS_FULL;
                  end else begin
                     rsp_data_in.status = STATUS_DONE;
                  end
               end else begin
                  if (row.found) begin
                     rsp_data_in.status          = STATUS_DONE;
                     rsp_data_in.lower_neighbour = 32'(lo_val);
                     rsp_data_in.upper_neighbour = 32'(hi_val);
                  end else begin
                     rsp_data_in.status          = STATUS_ABSENT;
                     rsp_data_in.lower_neighbour = invalid_ff;
                     rsp_data_in.upper_neighbour = invalid_ff;
                  end
               end
               if (insert_ok) begin
                  rsp_data_in.set_empty = 1'b0;
               end else if (remove_ok) begin
                  rsp_data_in.set_empty = !row.valid1;
               end else begin
                  rsp_data_in.set_empty = !row.valid0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         invalid_ff   <= 32'hFFFF_FFFF;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         invalid_ff   <= invalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      cmd_ff      <= cmd_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign cell_ctrl = '{cmp_en: accept,
                        cmp_key: id_type'(req_data.version_id),
                        upd_key: key_ff,
                        do_insert: insert_ok,
                        do_remove: remove_ok};

   // An accepted request blocks the next one until its update commits
   `SVS_ASSERT_NEXT(a_accept_blocks, clock, reset, accept, req_stall)
   // A new result only comes out of the update step
   `SVS_ASSERT_SAME(a_result_from_update, clock, reset, $rose(rsp_valid_ff),
                    $past(state_ff == ST_UPDATE))
   // A successful insert never leaves the set empty
   `SVS_ASSERT_NEXT(a_insert_not_empty, clock, reset, insert_ok,
                    rsp_valid_ff && !rsp_data_ff.set_empty)

endmodule

`default_nettype wire

// ===== hdl/sorted_version_set.sv =====
// ----------------------------------------------------------------------------
// sorted_version_set
// Ascending set of distinct version ids in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Each request runs in a compare step and an update step: in the cycle it
// is accepted every cell compares its id with the request id, and then, in
// the update step, the row shifts one place to open or close a gap while
// the result is written to the output register. A new request is taken
// only once that update step is done; the step waits only while an earlier
// result is still held by a stall. After reset the set holds the single id 0.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_version_set (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire svs_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output svs_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write_en,
   input  wire logic [31:0]      csr_write_data
);
   import svs_pkg::*;

   cell_ctrl_type  cell_ctrl;
   row_status_type row;
   link_type       links  [CAPACITY];
   link_type       lefts  [CAPACITY];
   link_type       rights [CAPACITY];
   logic           lo_hits[CAPACITY];
   logic           hi_hits[CAPACITY];

   // Wire each cell to its neighbors, tying off both ends
   always_comb begin
      lefts[0]           = '{id: '0, valid: 1'b1, lt: 1'b1, eq: 1'b0};
      rights[CAPACITY-1] = '{id: '0, valid: 1'b0, lt: 1'b0, eq: 1'b0};
      for (int i = 1; i < CAPACITY; i++) begin
         lefts[i]    = links[i-1];
         rights[i-1] = links[i];
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      svs_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .reset_valid ((g == 0) ? 1'b1 : 1'b0),
         .ctrl        (cell_ctrl),
         .left        (lefts[g]),
         .right       (rights[g]),
         .link_out    (links[g]),
         .lo_hit      (lo_hits[g]),
         .hi_hit      (hi_hits[g])
      );
   end

   // Gather match and neighbor ids from the row
   always_comb begin
      row        = '0;
      row.full   = links[CAPACITY-1].valid;
      row.valid0 = links[0].valid;
      row.valid1 = links[1].valid;
      for (int i = 0; i < CAPACITY; i++) begin
         row.found  = row.found | links[i].eq;
         row.lo_hit = row.lo_hit | lo_hits[i];
         row.hi_hit = row.hi_hit | hi_hits[i];
         row.lo_id  = row.lo_id | (lo_hits[i] ? links[i].id : '0);
         row.hi_id  = row.hi_id | (hi_hits[i] ? links[i].id : '0);
      end
   end

   svs_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .row            (row),
      .cell_ctrl      (cell_ctrl)
   );

endmodule

`default_nettype wire

// ===== sim/tb_sorted_version_set.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_version_set
// Self-checking testbench for the sorted version set.
// ----------------------------------------------------------------------------
// A short directed table covers the edge cases. It starts by emptying the
// set through removal of id 0, then covers absent removes, duplicates, the
// extreme ids and the wrap of the neighbor fields. Random phases follow.
// Each phase runs under its own invalid id value and its own insert/remove
// mix, so the store fills to capacity, drains to empty and refills.
// A predictor tracks its own copy of the set. Every accepted result is
// checked field by field against the oldest predicted result.
// ----------------------------------------------------------------------------

module tb_sorted_version_set;
   timeunit 1ns;
   timeprecision 1ps;

   import svs_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int PHASES         = 5;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_write_en;
   logic [31:0] csr_write_data;

   sorted_version_set dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // Predictor state: the ids in ascending order, their count, the register
   id_type      model_ids [CAPACITY];
   int          model_count;
   logic [31:0] model_invalid_id;

   rsp_type     predicted_results [$];
   int          error_count;
   int          requests_sent;
   int          status_seen [4];
   int          empty_seen;
   int          idle_cycles;
   bit          quiet_phase;

   typedef struct {
      logic        command;
      logic [31:0] version_id;
      bit          typed;
      rsp_type     rsp;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 20;

   // Rows with typed set carry their expected result; the rest use the predictor
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{CMD_REMOVE, 32'h0000_0000, 1'b1, '{STATUS_DONE, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1}},
      '{CMD_REMOVE, 32'h0000_0000, 1'b1, '{STATUS_ABSENT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}},
      '{CMD_INSERT, 32'h0000_0000, 1'b1, '{STATUS_DONE, 32'h0, 32'h0, 1'b0}},
      '{CMD_INSERT, 32'h0000_0000, 1'b1, '{STATUS_DUPLICATE, 32'h0, 32'h0, 1'b0}},
      '{CMD_INSERT, 32'hFFFF_FFFF, 1'b1, '{STATUS_DONE, 32'h0, 32'h0, 1'b0}},
      '{CMD_INSERT, 32'hFFFF_FFFF, 1'b1, '{STATUS_DUPLICATE, 32'h0, 32'h0, 1'b0}},
      '{CMD_REMOVE, 32'hFFFF_FFFF, 1'b1, '{STATUS_DONE, 32'h0000_0000, 32'h0000_0000, 1'b0}},
      '{CMD_REMOVE, 32'h0000_0000, 1'b1, '{STATUS_DONE, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1}},
      '{CMD_INSERT, 32'h8000_0000, 1'b0, '0},
      '{CMD_INSERT, 32'h7FFF_FFFF, 1'b0, '0},
      '{CMD_INSERT, 32'h5555_5555, 1'b0, '0},
      '{CMD_INSERT, 32'hAAAA_AAAA, 1'b0, '0},
      '{CMD_INSERT, 32'h0000_0001, 1'b0, '0},
      '{CMD_REMOVE, 32'h7FFF_FFFF, 1'b0, '0},
      '{CMD_REMOVE, 32'h0000_0001, 1'b0, '0},
      '{CMD_REMOVE, 32'hAAAA_AAAA, 1'b0, '0},
      '{CMD_REMOVE, 32'h1234_5678, 1'b1, '{STATUS_ABSENT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0}},
      '{CMD_INSERT, 32'h0000_0000, 1'b0, '0},
      '{CMD_INSERT, 32'hFFFF_FFFE, 1'b0, '0},
      '{CMD_REMOVE, 32'h8000_0000, 1'b0, '0}
   };

   // Random phases: request count and percentage of inserts
   int phase_items [PHASES]      = '{300, 300, 300, 400, 300};
   int phase_insert_pct [PHASES] = '{60, 85, 25, 50, 55};

   // Clock, 12 ns period
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Apply one request to the predicted set and return its result
   function automatic rsp_type apply_to_set(req_type r);
      rsp_type res;
      id_type  key;
      int      pos;
      bit      hit;
      key = id_type'(r.version_id);
      res = '0;
      pos = 0;
      while (pos < model_count && model_ids[pos] < key)
         pos++;
      hit = (pos < model_count) && (model_ids[pos] == key);
      if (r.command == CMD_INSERT) begin
         if (hit) begin
            res.status = STATUS_DUPLICATE;
         end else if (model_count >= CAPACITY) begin
            res.status = STATUS_FULL;
         end else begin
            for (int i = model_count; i > pos; i--)
               model_ids[i] = model_ids[i-1];
            model_ids[pos] = key;
            model_count++;
            res.status = STATUS_DONE;
         end
      end else begin
         if (!hit) begin
            res.status          = STATUS_ABSENT;
            res.lower_neighbour = model_invalid_id;
            res.upper_neighbour = model_invalid_id;
         end else begin
            res.status          = STATUS_DONE;
            res.lower_neighbour = (pos > 0) ? 32'(model_ids[pos-1]) : 32'(key - id_type'(1));
            res.upper_neighbour = (pos + 1 < model_count) ? 32'(model_ids[pos+1])
                                                          : 32'(key + id_type'(1));
            for (int i = pos; i + 1 < model_count; i++)
               model_ids[i] = model_ids[i+1];
            model_count--;
            model_ids[model_count] = '0;
         end
      end
      res.set_empty = (model_count == 0);
      return res;
   endfunction

   // Choose an id: for removes mostly members, for inserts members or their neighbors, a small pool, extremes
   function automatic logic [31:0] pick_version_id(bit for_remove);
      int unsigned sel;
      logic [31:0] v;
      sel = $urandom_range(0, 99);
      if (model_count != 0 && sel < (for_remove ? 70 : 20)) begin
         v = 32'(model_ids[$urandom_range(0, model_count - 1)]);
         if (!for_remove)
            v = v + 32'($urandom_range(0, 2)) - 32'd1;
      end else if (sel < 80) begin
         v = 32'($urandom_range(0, 95));
      end else if (sel < 92) begin
         v = $urandom();
      end else begin
         case ($urandom_range(0, 3))
            0: begin
               v = 32'h0000_0000;
            end
            1: begin
               v = 32'hFFFF_FFFF;
            end
            2: begin
               v = 32'h8000_0000;
            end
            default: begin
               v = 32'hFFFF_FFFE;
            end
         endcase
      end
      return v;
   endfunction

   // Send one request, with an optional idle gap, and record its result
   task automatic send_request(input req_type r, input bit typed, input rsp_type typed_rsp);
      rsp_type want;
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do
         @(posedge clock);
      while (!(req_valid && !req_stall));
      want = apply_to_set(r);
      if (typed)
         want = typed_rsp;
      predicted_results.push_back(want);
      requests_sent++;
   endtask

   // Drain outstanding results, then write the invalid id register
   task automatic write_invalid_id(input logic [31:0] value);
      req_valid <= 1'b0;
      while (predicted_results.size() != 0)
         @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      model_invalid_id = value;
      csr_write_en <= 1'b0;
   endtask

   // Stall the result channel in random bursts
   always begin
      @(posedge clock);
      if (!reset && !quiet_phase && $urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 18)) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // Check results and watch for a hang
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            idle_cycles <= 0;
            status_seen[rsp_data.status]++;
            if (rsp_data.set_empty)
               empty_seen++;
            if (predicted_results.size() == 0) begin
               $error("unexpected result: status %0d", rsp_data.status);
               error_count++;
            end else begin
               want = predicted_results.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.lower_neighbour !== want.lower_neighbour) begin
                  $error("lower_neighbour: expected %h, got %h",
                         want.lower_neighbour, rsp_data.lower_neighbour);
                  error_count++;
               end
               if (rsp_data.upper_neighbour !== want.upper_neighbour) begin
                  $error("upper_neighbour: expected %h, got %h",
                         want.upper_neighbour, rsp_data.upper_neighbour);
                  error_count++;
               end
               if (rsp_data.set_empty !== want.set_empty) begin
                  $error("set_empty: expected %0d, got %0d", want.set_empty, rsp_data.set_empty);
                  error_count++;
               end
            end
         end else if (req_valid && !req_stall) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_sorted_version_set: FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Main sequence
   initial begin
      req_type r;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_stall      = 1'b0;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      error_count    = 0;
      requests_sent  = 0;
      empty_seen     = 0;
      idle_cycles    = 0;
      quiet_phase    = 1'b0;
      status_seen    = '{0, 0, 0, 0};
      foreach (model_ids[i])
         model_ids[i] = '0;
      model_count      = 1;
      model_invalid_id = 32'hFFFF_FFFF;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         r.command    = directed_rows[i].command;
         r.version_id = directed_rows[i].version_id;
         send_request(r, directed_rows[i].typed, directed_rows[i].rsp);
      end

      // Random phases, each under its own invalid id; the last has no idling
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               write_invalid_id(32'h0000_0000);
            end
            1: begin
               write_invalid_id(32'hFFFF_FFFF);
            end
            default: begin
               write_invalid_id($urandom());
            end
         endcase
         quiet_phase = (p == PHASES - 1);
         for (int n = 0; n < phase_items[p]; n++) begin
            r.command    = ($urandom_range(0, 99) < phase_insert_pct[p]) ? CMD_INSERT
                                                                          : CMD_REMOVE;
            r.version_id = pick_version_id(r.command == CMD_REMOVE);
            send_request(r, 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      // Drain, then allow stray results to show up
      while (predicted_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d requests: %0d done, %0d duplicate, %0d absent, %0d store full",
               requests_sent, status_seen[STATUS_DONE], status_seen[STATUS_DUPLICATE],
               status_seen[STATUS_ABSENT], status_seen[STATUS_FULL]);
      $display("%0d results reported an empty set, %0d mismatches", empty_seen, error_count);
      if (error_count == 0)
         $display("tb_sorted_version_set: PASS");
      else
         $display("tb_sorted_version_set: FAIL");
      $finish;
   end

endmodule
